[rtl/bcd_pkg.sv]
`default_nettype none

package bcd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_STACK_MODE    = 3'd0;
    localparam logic [2:0] REG_STACK_COLOR_0 = 3'd1;
    localparam logic [2:0] REG_STACK_COLOR_1 = 3'd2;
    localparam logic [2:0] REG_STACK_COLOR_2 = 3'd3;
    localparam logic [2:0] REG_STACK_COLOR_3 = 3'd4;

    localparam logic [13:0] SQUARES_SEL_MASK = 14'h1800;
    localparam logic [13:0] SQUARES_SEL_CODE = 14'h1000;
    localparam logic [13:0] ROM_BASE         = 14'h3000;
    localparam logic [13:0] STACK_ROM_MASK   = 14'h07F8;
    localparam logic [13:0] GLYPH_MASK       = 14'h01F8;
    localparam logic [4:0]  FG_MARK          = 5'h10;
    localparam logic [2:0]  STACK_SQUARE     = 3'd7;

    typedef struct packed {
        logic [4:0]  tile_col;
        logic [3:0]  tile_row;
        logic        squares_mode;
        logic        from_rom;
        logic [13:0] glyph_address;
        logic [4:0]  fore_color;
        logic [3:0]  back_color;
        logic [4:0]  square_color_0;
        logic [4:0]  square_color_1;
        logic [4:0]  square_color_2;
        logic [4:0]  square_color_3;
    } result_t;

    // A square of color 7 shows the current stack color without the foreground mark
    function automatic logic [4:0] square_color(input logic [2:0] c, input logic [3:0] cs);
        logic [4:0] res;
        if (c == STACK_SQUARE)
        begin
            res = {1'b0, cs};
        end
        else
        begin
            res = FG_MARK | {2'b00, c};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/background_card_decoder_unit.sv]
// Background card decoder.
// Input stream: one card word per transaction, s_tdata[13:0] = card_word,
// s_tuser[0] = frame_start (clears stack pointer, column and row before the
// card is decoded). Output stream: one decoded result per input card, with
// m_tuser[0] = squares_mode and the remaining fields packed in m_tdata.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
// stack_mode (0) or stack colors 0..3 (1..4); other indexes are dropped.
// cfg_ready is always high; write only while the block is idle.
// m_tvalid rises in the cycle after an input transaction. Throughput: one card
// per cycle while the receiver does not stall, set by the single output register;
// the decode, the pointer step and the tile counters are all combinational.
// Reset: config registers, stack pointer and tile counters clear, m_tvalid low; the payload register is not reset.
// When the receiver stalls, the output register holds its result and
// s_tready drops until the result is taken; s_tready is high in a cycle in
// which the held result leaves, so the stream keeps full rate.
`default_nettype none

module background_card_decoder_unit #(
    parameter int TILES_PER_ROW = 20,
    parameter int TILE_ROWS     = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [13:0] card_word, [15:14] zero
    input  wire logic [0:0]  s_tuser,   // [0] frame_start
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [4:0] tile_col, [8:5] tile_row, [9] from_rom,
                                        // [23:10] glyph_address, [28:24] fore_color,
                                        // [32:29] back_color, [37:33] square_color_0,
                                        // [42:38] square_color_1, [47:43] square_color_2,
                                        // [52:48] square_color_3, [55:53] zero
    output logic [0:0]       m_tuser    // [0] squares_mode
);

    localparam logic [4:0] COL_LAST = 5'(TILES_PER_ROW - 1);
    localparam logic [3:0] ROW_LAST = 4'(TILE_ROWS - 1);
    localparam logic [4:0] COL_AFTER_FIRST = (TILES_PER_ROW == 1) ? 5'd0 : 5'd1;

    logic                 stack_mode_reg;
    logic [3:0]           stack_color_reg [4];
    logic [1:0]           ptr_reg;
    logic [1:0]           ptr_next;
    logic [4:0]           col_reg;
    logic [4:0]           col_next;
    logic [3:0]           row_reg;
    logic [3:0]           row_next;
    logic                 out_valid_reg;
    bcd_pkg::result_t     out_reg;
    bcd_pkg::result_t     out_next;

    logic        in_accept;
    logic [13:0] card;
    logic        fs;
    logic [1:0]  ptr_base;
    logic [4:0]  col_base;
    logic [3:0]  row_base;
    logic        is_squares;
    logic [3:0]  cs;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign card      = s_tdata[13:0];
    assign fs        = s_tuser[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_mode_reg     <= 1'b0;
            stack_color_reg[0] <= 4'd0;
            stack_color_reg[1] <= 4'd0;
            stack_color_reg[2] <= 4'd0;
            stack_color_reg[3] <= 4'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bcd_pkg::REG_STACK_MODE:    stack_mode_reg     <= cfg_data[0];
                bcd_pkg::REG_STACK_COLOR_0: stack_color_reg[0] <= cfg_data;
                bcd_pkg::REG_STACK_COLOR_1: stack_color_reg[1] <= cfg_data;
                bcd_pkg::REG_STACK_COLOR_2: stack_color_reg[2] <= cfg_data;
                bcd_pkg::REG_STACK_COLOR_3: stack_color_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ptr_base   = fs ? 2'd0 : ptr_reg;
        col_base   = fs ? 5'd0 : col_reg;
        row_base   = fs ? 4'd0 : row_reg;
        is_squares = stack_mode_reg
                     && ((card & bcd_pkg::SQUARES_SEL_MASK) == bcd_pkg::SQUARES_SEL_CODE);

        // advance the pointer on a stack-mode glyph card with bit 13 set
        ptr_next = ptr_base;
        if (stack_mode_reg && !is_squares && card[13])
        begin
            ptr_next = ptr_base + 2'd1;
        end
        cs = stack_color_reg[ptr_next];

        if (col_base == COL_LAST)
        begin
            col_next = 5'd0;
            row_next = (row_base == ROW_LAST) ? 4'd0 : row_base + 4'd1;
        end
        else
        begin
            col_next = col_base + 5'd1;
            row_next = row_base;
        end

        out_next                = '0;
        out_next.tile_col       = col_base;
        out_next.tile_row       = row_base;
        out_next.squares_mode   = is_squares;
        if (is_squares)
        begin
            out_next.square_color_0 = bcd_pkg::square_color(card[2:0], cs);
            out_next.square_color_1 = bcd_pkg::square_color(card[5:3], cs);
            out_next.square_color_2 = bcd_pkg::square_color(card[8:6], cs);
            out_next.square_color_3 = bcd_pkg::square_color({card[13], card[10:9]}, cs);
        end
        else if (stack_mode_reg)
        begin
            out_next.from_rom      = !card[11];
            out_next.glyph_address = card[11] ? (card & bcd_pkg::GLYPH_MASK)
                                   : (bcd_pkg::ROM_BASE | (card & bcd_pkg::STACK_ROM_MASK));
            out_next.fore_color    = bcd_pkg::FG_MARK | {1'b0, card[12], card[2:0]};
            out_next.back_color    = cs;
        end
        else
        begin
            out_next.from_rom      = !card[11];
            out_next.glyph_address = card[11] ? (card & bcd_pkg::GLYPH_MASK)
                                   : (bcd_pkg::ROM_BASE | (card & bcd_pkg::GLYPH_MASK));
            out_next.fore_color    = bcd_pkg::FG_MARK | {2'b00, card[2:0]};
            out_next.back_color    = {card[12], card[13], card[10], card[9]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= 2'd0;
            col_reg       <= 5'd0;
            row_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                ptr_reg       <= ptr_next;
                col_reg       <= col_next;
                row_reg       <= row_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload register: load on every accepted card
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_reg.squares_mode;
    assign m_tdata    = {3'b000,
                         out_reg.square_color_3,
                         out_reg.square_color_2,
                         out_reg.square_color_1,
                         out_reg.square_color_0,
                         out_reg.back_color,
                         out_reg.fore_color,
                         out_reg.glyph_address,
                         out_reg.from_rom,
                         out_reg.tile_row,
                         out_reg.tile_col};

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_LAST)
        else $error("column counter out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_LAST)
        else $error("row counter out of range");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && fs) |=> (col_reg == COL_AFTER_FIRST) && (m_tdata[4:0] == 5'd0))
        else $error("frame start did not restart the tile counters");

    a_fgbg_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !fs && !stack_mode_reg) |=> $stable(ptr_reg))
        else $error("stack pointer moved in foreground/background mode");

endmodule

`default_nettype wire

[sim/background_card_decoder_unit_tb.sv]
`default_nettype none

module background_card_decoder_unit_tb;

    localparam int TILE_COLS      = 20;
    localparam int TILE_ROW_COUNT = 12;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_CARDS    = 150;
    localparam logic [2:0] REG_INDEX_MAX = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [3:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;

    // predictor state and register shadow
    logic       shadow_stack_mode;
    logic [3:0] shadow_stack_color [4];
    logic [1:0] stack_ptr;
    logic [4:0] col_count;
    logic [3:0] row_count;

    bcd_pkg::result_t decoded_cards [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      stall_left     = 0;
    bit      full_rate      = 1'b0;

    background_card_decoder_unit #(
        .TILES_PER_ROW(TILE_COLS),
        .TILE_ROWS    (TILE_ROW_COUNT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly zero, sometimes a few cycles, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 24);
    endfunction

    function automatic logic [4:0] square_shade(input logic [2:0] c, input logic [3:0] cs);
        return (c == bcd_pkg::STACK_SQUARE) ? {1'b0, cs} : {2'b10, c};
    endfunction

    task automatic decode_card(input logic [13:0] card, input logic frame_start);
        bcd_pkg::result_t r;
        logic [3:0]       cs;
        r = '0;
        if (frame_start)
        begin
            stack_ptr = '0;
            col_count = '0;
            row_count = '0;
        end
        if (shadow_stack_mode)
        begin
            if ((card & bcd_pkg::SQUARES_SEL_MASK) == bcd_pkg::SQUARES_SEL_CODE)
            begin
                cs = shadow_stack_color[stack_ptr];
                r.squares_mode   = 1'b1;
                r.square_color_0 = square_shade(card[2:0], cs);
                r.square_color_1 = square_shade(card[5:3], cs);
                r.square_color_2 = square_shade(card[8:6], cs);
                r.square_color_3 = square_shade({card[13], card[10], card[9]}, cs);
            end
            else
            begin
                // advance the stack before the background lookup
                if (card[13])
                    stack_ptr = stack_ptr + 2'd1;
                r.fore_color    = {1'b1, card[12], card[2:0]};
                r.back_color    = shadow_stack_color[stack_ptr];
                r.from_rom      = ~card[11];
                r.glyph_address = r.from_rom
                                ? bcd_pkg::ROM_BASE + (card & bcd_pkg::STACK_ROM_MASK)
                                : (card & bcd_pkg::GLYPH_MASK);
            end
        end
        else
        begin
            r.fore_color    = {2'b10, card[2:0]};
            r.back_color    = {card[12], card[13], card[10], card[9]};
            r.from_rom      = ~card[11];
            r.glyph_address = r.from_rom ? bcd_pkg::ROM_BASE + (card & bcd_pkg::GLYPH_MASK)
                                         : (card & bcd_pkg::GLYPH_MASK);
        end
        r.tile_col = col_count;
        r.tile_row = row_count;
        decoded_cards.push_back(r);
        if (col_count == TILE_COLS - 1)
        begin
            col_count = '0;
            row_count = (row_count == TILE_ROW_COUNT - 1) ? 4'd0 : row_count + 4'd1;
        end
        else
        begin
            col_count = col_count + 5'd1;
        end
    endtask

    task automatic send_card(input logic [13:0] card, input logic frame_start);
        int gap;
        s_tdata  <= {2'b00, card};
        s_tuser  <= frame_start;
        s_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        decode_card(card, frame_start);
        gap = full_rate ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the stream until every decoded card has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (decoded_cards.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [3:0] data, input bit last);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            bcd_pkg::REG_STACK_MODE:    shadow_stack_mode     = data[0];
            bcd_pkg::REG_STACK_COLOR_0: shadow_stack_color[0] = data;
            bcd_pkg::REG_STACK_COLOR_1: shadow_stack_color[1] = data;
            bcd_pkg::REG_STACK_COLOR_2: shadow_stack_color[2] = data;
            bcd_pkg::REG_STACK_COLOR_3: shadow_stack_color[3] = data;
            default: ;
        endcase
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input logic mode, input logic [3:0] c0, input logic [3:0] c1,
                               input logic [3:0] c2, input logic [3:0] c3);
        write_reg(bcd_pkg::REG_STACK_MODE, {3'b000, mode}, 1'b0);
        write_reg(bcd_pkg::REG_STACK_COLOR_0, c0, 1'b0);
        write_reg(bcd_pkg::REG_STACK_COLOR_1, c1, 1'b0);
        write_reg(bcd_pkg::REG_STACK_COLOR_2, c2, 1'b0);
        write_reg(bcd_pkg::REG_STACK_COLOR_3, c3, 1'b1);
    endtask

    task automatic test_reset_state();
        send_card(14'h0000, 1'b1);
        send_card(14'h3FFF, 1'b0);
        send_card(14'h1007, 1'b0);
    endtask

    task automatic test_fore_back_mode();
        wait_idle();
        load_config(1'b0, 4'hF, 4'hF, 4'hF, 4'hF);
        send_card(14'h0800, 1'b0);
        send_card(14'h07F8, 1'b0);
        send_card(14'h3600, 1'b0);
        send_card(14'h1FFF, 1'b0);
    endtask

    task automatic test_color_stack();
        wait_idle();
        load_config(1'b1, 4'h0, 4'hF, 4'h5, 4'hA);
        send_card(14'h37FF, 1'b1);   // squares, all four from the stack
        send_card(14'h1000, 1'b0);   // squares, none from the stack
        send_card(14'h1123, 1'b0);
        // step the pointer through all entries and wrap
        send_card(14'h2000, 1'b0);
        send_card(14'h3FFF, 1'b0);
        send_card(14'h27F8, 1'b0);
        send_card(14'h2807, 1'b0);
        send_card(14'h1007, 1'b0);
        send_card(14'h1FFF, 1'b0);
        send_card(14'h0000, 1'b0);
        // frame start clears the pointer before the card is decoded
        send_card(14'h2000, 1'b0);
        send_card(14'h1007, 1'b1);
    endtask

    task automatic test_unused_index();
        wait_idle();
        for (int i = bcd_pkg::REG_STACK_COLOR_3 + 1; i <= REG_INDEX_MAX; i++)
            write_reg(i[2:0], 4'hF, i == REG_INDEX_MAX);
        send_card(14'h1007, 1'b0);
        send_card(14'h2000, 1'b0);
    endtask

    task automatic test_mode_switch();
        wait_idle();
        load_config(1'b1, 4'h3, 4'h6, 4'h9, 4'hC);
        send_card(14'h2000, 1'b1);
        wait_idle();
        write_reg(bcd_pkg::REG_STACK_MODE, 4'h0, 1'b1);
        send_card(14'h2000, 1'b0);
        send_card(14'h1007, 1'b0);
        wait_idle();
        // pointer must have survived the detour through the other mode
        write_reg(bcd_pkg::REG_STACK_MODE, 4'h1, 1'b1);
        send_card(14'h1007, 1'b0);
    endtask

    task automatic test_random_cards();
        logic [13:0] card;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            case (phase)
                0: load_config(1'b1, 4'h0, 4'h0, 4'h0, 4'h0);
                1: load_config(1'b1, 4'hF, 4'hF, 4'hF, 4'hF);
                2: load_config(1'b0, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                               4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                default: load_config(phase != 5, 4'($urandom_range(0, 15)),
                                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                     4'($urandom_range(0, 15)));
            endcase
            full_rate = (phase == 4);
            for (int n = 0; n < PHASE_CARDS; n++)
            begin
                card = 14'($urandom_range(0, 16383));
                // bias toward squares cards
                if ($urandom_range(0, 99) < 30)
                    card = (card & ~bcd_pkg::SQUARES_SEL_MASK) | bcd_pkg::SQUARES_SEL_CODE;
                if (n == PHASE_CARDS / 2)
                    wait_idle();
                send_card(card, (n == 0) ? 1'($urandom_range(0, 1))
                                         : ($urandom_range(0, 299) == 0));
            end
            full_rate = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (full_rate)
        begin
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
                stall_left = pick_gap();
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        bcd_pkg::result_t got;
        bcd_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.tile_col       = m_tdata[4:0];
            got.tile_row       = m_tdata[8:5];
            got.squares_mode   = m_tuser[0];
            got.from_rom       = m_tdata[9];
            got.glyph_address  = m_tdata[23:10];
            got.fore_color     = m_tdata[28:24];
            got.back_color     = m_tdata[32:29];
            got.square_color_0 = m_tdata[37:33];
            got.square_color_1 = m_tdata[42:38];
            got.square_color_2 = m_tdata[47:43];
            got.square_color_3 = m_tdata[52:48];
            if (decoded_cards.size() == 0)
            begin
                $display("%0t: unexpected transaction: expected none, actual %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = decoded_cards.pop_front();
                check_field("tile_col", int'(want.tile_col), int'(got.tile_col));
                check_field("tile_row", int'(want.tile_row), int'(got.tile_row));
                check_field("squares_mode", int'(want.squares_mode), int'(got.squares_mode));
                check_field("from_rom", int'(want.from_rom), int'(got.from_rom));
                check_field("glyph_address", int'(want.glyph_address),
                            int'(got.glyph_address));
                check_field("fore_color", int'(want.fore_color), int'(got.fore_color));
                check_field("back_color", int'(want.back_color), int'(got.back_color));
                check_field("square_color_0", int'(want.square_color_0),
                            int'(got.square_color_0));
                check_field("square_color_1", int'(want.square_color_1),
                            int'(got.square_color_1));
                check_field("square_color_2", int'(want.square_color_2),
                            int'(got.square_color_2));
                check_field("square_color_3", int'(want.square_color_3),
                            int'(got.square_color_3));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, decoded_cards.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        shadow_stack_mode = 1'b0;
        for (int i = 0; i < 4; i++)
            shadow_stack_color[i] = '0;
        stack_ptr = '0;
        col_count = '0;
        row_count = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_fore_back_mode();
        test_color_stack();
        test_unused_index();
        test_mode_switch();
        test_random_cards();
        wait_idle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
